// ===== hw/rtl/mmcs_pkg.sv =====
// shared types and constants for the min-max contrast stretch block
package mmcs_pkg;

    localparam int unsigned PIX_W     = 16;
    localparam int unsigned QDEPTH    = 4;
    localparam int unsigned QAW       = $clog2(QDEPTH);
    localparam int unsigned DIV_STEPS = PIX_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
    localparam int unsigned NUM_W     = 2 * PIX_W + 2;
    localparam int unsigned REM_W     = PIX_W + 1;

    localparam logic [PIX_W-1:0] FULL8  = 16'h00FF;
    localparam logic [PIX_W-1:0] FULL16 = 16'hFFFF;

    localparam logic REQ_MEASURE = 1'b0;
    localparam logic REQ_MAP     = 1'b1;

    typedef enum logic [0:0] {
        K_VALUE = 1'b0,
        K_DIV   = 1'b1
    } t_kind;

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] pixel_in;
        logic             last_in;
    } t_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_out;
    } t_out;

    // one classified map pixel; val is the result or the offset above min
    typedef struct packed {
        t_kind            kind;
        logic             wide;
        logic             last;
        logic [PIX_W-1:0] val;
        logic [PIX_W-1:0] span;
    } t_job;

endpackage

// ===== hw/rtl/mmcs_front.sv =====
// front part: config register, min/max tracking and map pixel classification
module mmcs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mmcs_pkg::t_in  i_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           i_q_full,
    output logic           o_push,
    output mmcs_pkg::t_job o_job
);
    import mmcs_pkg::*;

    logic             r_wide, n_wide;
    logic [PIX_W-1:0] r_run_min, n_run_min;
    logic [PIX_W-1:0] r_run_max, n_run_max;
    logic [PIX_W-1:0] r_frame_min, n_frame_min;
    logic [PIX_W-1:0] r_frame_max, n_frame_max;

    logic             acc;
    logic [PIX_W-1:0] full, pix, lo, hi, mn, mx;

    always_comb begin
        full = r_wide ? FULL16 : FULL8;
        pix  = i_data.pixel_in & full;
        lo   = r_frame_min & full;
        hi   = r_frame_max & full;
        acc  = i_valid && !i_q_full;
        mn   = (pix < r_run_min) ? pix : r_run_min;
        mx   = (pix > r_run_max) ? pix : r_run_max;

        n_wide      = i_cfg_we ? i_cfg_wdata : r_wide;
        n_run_min   = r_run_min;
        n_run_max   = r_run_max;
        n_frame_min = r_frame_min;
        n_frame_max = r_frame_max;

        if (acc && i_data.req_type == REQ_MEASURE) begin
            if (i_data.last_in) begin
                n_frame_min = mn;
                n_frame_max = mx;
                n_run_min   = FULL16;
                n_run_max   = '0;
            end else begin
                n_run_min = mn;
                n_run_max = mx;
            end
        end

        o_push      = acc && i_data.req_type == REQ_MAP;
        o_job.wide  = r_wide;
        o_job.last  = i_data.last_in;
        o_job.kind  = K_VALUE;
        o_job.span  = hi - lo;
        o_job.val   = '0;
        priority if (lo == '0 && hi == full) begin
            o_job.val = pix;
        end else if (hi <= lo || pix <= lo) begin
            o_job.val = '0;
        end else if (pix >= hi) begin
            o_job.val = full;
        end else begin
            o_job.kind = K_DIV;
            o_job.val  = pix - lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide      <= 1'b0;
            r_run_min   <= FULL16;
            r_run_max   <= '0;
            r_frame_min <= '0;
            r_frame_max <= FULL16;
        end else begin
            r_wide      <= n_wide;
            r_run_min   <= n_run_min;
            r_run_max   <= n_run_max;
            r_frame_min <= n_frame_min;
            r_frame_max <= n_frame_max;
        end
    end

endmodule

// ===== hw/rtl/mmcs_queue.sv =====
// short job queue between the front and back parts
module mmcs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mmcs_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mmcs_pkg::t_job o_job
);
    import mmcs_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QAW:0]   r_cnt, n_cnt;

    always_comb begin
        o_full  = r_cnt == (QAW+1)'(QDEPTH);
        o_empty = r_cnt == '0;
        o_job   = r_mem[r_rp];
        n_wp    = i_push ? r_wp + 1'b1 : r_wp;
        n_rp    = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt   = r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/mmcs_back.sv =====
// back part: bit-serial rounding divider and output register
module mmcs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  mmcs_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    output mmcs_pkg::t_out o_data,
    input  logic           i_stall
);
    import mmcs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [PIX_W-1:0] r_num, n_num;
    logic [REM_W-1:0] r_div, n_div;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;
    logic             r_ovalid, n_ovalid;
    t_out             r_odata, n_odata;

    logic             out_free;
    logic [NUM_W-1:0] fd, num;
    logic [REM_W:0]   trial;
    logic             ge;

    always_comb begin
        out_free = !r_ovalid || !i_stall;
        // full*d as a shift and subtract, then 2*full*d + span
        fd = i_job.wide ? ({2'b0, i_job.val, 16'b0} - {18'b0, i_job.val})
                        : ({10'b0, i_job.val, 8'b0} - {18'b0, i_job.val});
        num   = {fd[NUM_W-2:0], 1'b0} + {18'b0, i_job.span};
        trial = {r_rem, r_num[PIX_W-1]};
        ge    = trial >= {1'b0, r_div};

        n_state  = r_state;
        n_rem    = r_rem;
        n_num    = r_num;
        n_div    = r_div;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_ovalid = r_ovalid && i_stall;
        n_odata  = r_odata;
        o_pop    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_job.kind == K_VALUE) begin
                        if (out_free) begin
                            o_pop             = 1'b1;
                            n_ovalid          = 1'b1;
                            n_odata.pixel_out = i_job.val;
                            n_odata.last_out  = i_job.last;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_rem   = num[NUM_W-2:PIX_W];
                        n_num   = num[PIX_W-1:0];
                        n_div   = {i_job.span, 1'b0};
                        n_cnt   = '0;
                        n_last  = i_job.last;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem = ge ? REM_W'(trial - {1'b0, r_div}) : trial[REM_W-1:0];
                n_num = {r_num[PIX_W-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_ovalid          = 1'b1;
                    n_odata.pixel_out = r_num;
                    n_odata.last_out  = r_last;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_valid = r_ovalid;
        o_data  = r_odata;
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_num   <= n_num;
        r_div   <= n_div;
        r_cnt   <= n_cnt;
        r_last  <= n_last;
        r_odata <= n_odata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ===== hw/rtl/min_max_contrast_stretch.sv =====
// Min-max contrast stretch of an 8- or 16-bit grayscale frame.
// Input channel i_valid/o_stall/i_data: each frame is sent twice. Measure
// words (req_type 0) update the running min and max and give no output;
// the measure word marked last latches them as the frame's range. Map words
// (req_type 1) each give one output word on o_valid/i_stall/o_data,
// round(full*(p-min)/(max-min)), with last_out copied from last_in.
// i_cfg_we/i_cfg_wdata select the pixel width (1 = 16-bit); write only
// while the block is idle.
// Timing: the front takes one word a cycle while its 4-deep job queue has
// room. Map words that pass through or clamp go through the job queue and
// the output register and stream at one a cycle while i_stall is low. A
// word that needs the ratio runs through a bit-serial divider, 16 steps,
// one quotient bit per cycle, then waits in a hold state for the output
// register; the back end takes no other word until that one is out.
// Reset clears the queue and output, sets 8-bit mode and an identity range
// (min 0, max full scale). When the receiver stalls, the output word holds,
// the queue fills, and o_stall rises once it is full.
module min_max_contrast_stretch (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mmcs_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output mmcs_pkg::t_out o_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata
);
    import mmcs_pkg::*;

    logic q_full, q_empty, push, pop;
    t_job push_job, pop_job;

    assign o_stall = q_full;

    mmcs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    mmcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (pop_job)
    );

    mmcs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (pop_job),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

// ===== hw/rtl/mmcs_checker.sv =====
// port-level checks for the contrast stretch block, bound to the top level
module mmcs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input mmcs_pkg::t_in  i_data,
    input logic           o_valid,
    input logic           i_stall,
    input mmcs_pkg::t_out o_data,
    input logic           i_cfg_we,
    input logic           i_cfg_wdata
);
    import mmcs_pkg::*;

    logic r_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b0;
        end else if (i_cfg_we) begin
            r_wide <= i_cfg_wdata;
        end
    end

    // stalled input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data))
        else $error("input word changed under stall");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output word changed under stall");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

    // 8-bit mode never yields a value above 255
    a_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !r_wide |-> o_data.pixel_out[15:8] == 8'h00)
        else $error("upper byte set in 8-bit mode");

endmodule

bind min_max_contrast_stretch mmcs_checker u_mmcs_checker (.*);

// ===== tb/min_max_contrast_stretch_checker.sv =====
// stream checker for the min-max contrast stretch block: predicts and compares output words
module min_max_contrast_stretch_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  mmcs_pkg::t_in  i_in_word,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  mmcs_pkg::t_out i_out_word,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    output int             o_pending,
    output int             o_errors
);
    import mmcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic             wide_mode;
    logic [PIX_W-1:0] run_lo;
    logic [PIX_W-1:0] run_hi;
    logic [PIX_W-1:0] frame_lo;
    logic [PIX_W-1:0] frame_hi;
    t_out             pending_pixels[$];

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        o_errors++;
    endtask

    // rounded full*(p-lo)/(hi-lo), halves rounded up, done exactly in integers
    function automatic logic [PIX_W-1:0] stretched(logic [PIX_W-1:0] p,
                                                   logic [PIX_W-1:0] full,
                                                   logic [PIX_W-1:0] lo,
                                                   logic [PIX_W-1:0] hi);
        logic [63:0] d;
        logic [63:0] span;
        logic [63:0] q;
        if (lo == '0 && hi == full) return p;
        if (hi <= lo || p <= lo) return '0;
        if (p >= hi) return full;
        d    = 64'(p - lo);
        span = 64'(hi - lo);
        q    = (2 * 64'(full) * d + span) / (2 * span);
        return q[PIX_W-1:0];
    endfunction

    task automatic take_pixel(t_in w);
        logic [PIX_W-1:0] full;
        logic [PIX_W-1:0] p;
        t_out             res;
        full = wide_mode ? FULL16 : FULL8;
        p    = w.pixel_in & full;
        if (w.req_type == REQ_MEASURE) begin
            if (p < run_lo) run_lo = p;
            if (p > run_hi) run_hi = p;
            if (w.last_in) begin
                frame_lo = run_lo;
                frame_hi = run_hi;
                run_lo   = '1;
                run_hi   = '0;
            end
        end else begin
            res.pixel_out = stretched(p, full, frame_lo & full, frame_hi & full);
            res.last_out  = w.last_in;
            pending_pixels.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            wide_mode = 1'b0;
            run_lo    = '1;
            run_hi    = '0;
            frame_lo  = '0;
            frame_hi  = '1;
            o_errors  = 0;
            pending_pixels.delete();
        end else begin
            if (i_cfg_we) wide_mode = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected word pixel_out=%h last_out=%b",
                                              i_out_word.pixel_out, i_out_word.last_out));
                end else begin
                    want = pending_pixels.pop_front();
                    if (i_out_word.pixel_out !== want.pixel_out)
                        report_mismatch($sformatf("pixel_out got %h want %h",
                                                  i_out_word.pixel_out, want.pixel_out));
                    if (i_out_word.last_out !== want.last_out)
                        report_mismatch($sformatf("last_out got %b want %b",
                                                  i_out_word.last_out, want.last_out));
                end
            end
            if (i_in_valid && !i_in_stall) take_pixel(i_in_word);
        end
        o_pending <= pending_pixels.size();
    end

endmodule

// ===== tb/min_max_contrast_stretch_tb.sv =====
// testbench top for the min-max contrast stretch block: stimulus, idling and verdict
module min_max_contrast_stretch_tb;
    import mmcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic WIDTH_8  = 1'b0;
    localparam logic WIDTH_16 = 1'b1;
    localparam int   SETTLE   = 40;
    localparam int   QUIET_LIMIT = 3000;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_valid     = 1'b0;
    t_in  i_data      = '0;
    logic i_stall     = 1'b0;
    logic i_cfg_we    = 1'b0;
    logic i_cfg_wdata = 1'b0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    int pending;
    int errors;
    int quiet = 0;
    int send_idle_pct = 32;
    int recv_idle_pct = 88;

    min_max_contrast_stretch dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    min_max_contrast_stretch_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_word   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_word  (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) i_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
        else quiet <= quiet + 1;
    end

    initial begin
        while (quiet < QUIET_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_word(logic req, logic [PIX_W-1:0] pix, logic last);
        t_in w;
        w.req_type = req;
        w.pixel_in = pix;
        w.last_in  = last;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    // wait for every predicted word, then give the divider time to go quiet
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_width(logic wide);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= wide;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // frames sent twice: measure pass then map pass, with some noise and broken frames
    task automatic run_frames(int quota);
        int               sent;
        int               kind;
        int               npix;
        int               span;
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] frame_pix[$];
        sent = 0;
        while (sent < quota) begin
            kind = $urandom_range(15);
            if (kind == 0) begin
                send_word(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)));
                sent++;
            end else begin
                npix = $urandom_range(1, 12);
                case ($urandom_range(3))
                    0: span = $urandom_range(3);
                    1: span = 255;
                    2: span = 4095;
                    default: span = 65535;
                endcase
                base = 16'($urandom);
                frame_pix.delete();
                repeat (npix) frame_pix.push_back(16'(base + $urandom_range(span)));
                // full-range frame gives the pass-through mapping
                if (kind == 3) begin
                    frame_pix[0]      = '0;
                    frame_pix[npix-1] = '1;
                end
                // kind 1 leaves the measure pass open, kind 2 the map pass
                foreach (frame_pix[i])
                    send_word(REQ_MEASURE, frame_pix[i], (kind != 1) && (i == npix - 1));
                foreach (frame_pix[i])
                    send_word(REQ_MAP,
                              ($urandom_range(7) == 0) ? 16'($urandom) : frame_pix[i],
                              (kind != 2) && (i == npix - 1));
                sent += 2 * npix;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_width(WIDTH_8);

        // identity range straight after reset, upper byte ignored
        send_word(REQ_MAP, 16'h12AB, 1'b0);
        send_word(REQ_MAP, 16'hFF00, 1'b0);
        send_word(REQ_MAP, 16'h00FF, 1'b1);
        // ordinary frame, pixels below, at and above the range
        send_word(REQ_MEASURE, 16'h0040, 1'b0);
        send_word(REQ_MEASURE, 16'h0180, 1'b0);
        send_word(REQ_MEASURE, 16'h00C0, 1'b1);
        send_word(REQ_MAP, 16'h0030, 1'b0);
        send_word(REQ_MAP, 16'h0040, 1'b0);
        send_word(REQ_MAP, 16'h0041, 1'b0);
        send_word(REQ_MAP, 16'h0080, 1'b0);
        send_word(REQ_MAP, 16'h00C0, 1'b0);
        send_word(REQ_MAP, 16'hAAFF, 1'b1);
        // constant frame maps to zero
        send_word(REQ_MEASURE, 16'h0077, 1'b0);
        send_word(REQ_MEASURE, 16'h1177, 1'b1);
        send_word(REQ_MAP, 16'h0077, 1'b0);
        send_word(REQ_MAP, 16'h00FF, 1'b1);
        drain();
        set_width(WIDTH_16);
        send_word(REQ_MEASURE, 16'h0000, 1'b0);
        send_word(REQ_MEASURE, 16'hFFFF, 1'b1);
        send_word(REQ_MAP, 16'h8001, 1'b0);
        send_word(REQ_MAP, 16'hFFFF, 1'b1);
        // range that inverts once masked to 8 bits
        send_word(REQ_MEASURE, 16'h00F0, 1'b0);
        send_word(REQ_MEASURE, 16'h0110, 1'b1);
        send_word(REQ_MAP, 16'h0100, 1'b1);
        drain();
        set_width(WIDTH_8);
        send_word(REQ_MAP, 16'h0050, 1'b1);
        drain();

        set_width(WIDTH_16);
        run_frames(300);
        drain();

        send_idle_pct = 88;
        recv_idle_pct = 32;
        set_width(WIDTH_8);
        run_frames(300);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_width(WIDTH_16);
        run_frames(150);
        drain();
        set_width(WIDTH_8);
        run_frames(150);
        drain();

        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
